// ----- hdl/source_text_tokenizer_core_defines.svh -----
// Assertion macros shared by the source text tokenizer core.
`ifndef SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`define SOURCE_TEXT_TOKENIZER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define STT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("stt: check failed");
`define STT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("stt: check failed");
`else
`define STT_ASSERT(lbl, prop)
`define STT_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

// ----- hdl/stt_pkg.sv -----
// Shared types, constants and character helpers of the tokenizer.
package stt_pkg;

  localparam int POS_BITS = 32;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);
  localparam logic [POS_BITS-1:0] POS_TWO = POS_BITS'(2);
  localparam logic [POS_BITS-1:0] POS_ZERO = '0;
  localparam logic [POS_BITS-1:0] KW_MAX_LEN = POS_BITS'(8);

  localparam int QDEPTH = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);
  localparam int QCNT_BITS = $clog2(QDEPTH + 1);

  localparam int KW_COUNT = 13;
  localparam logic [KW_COUNT-1:0] KW_ALL = {KW_COUNT{1'b1}};

  // Keyword text, first character in the top byte.
  localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
    {"set", 40'd0}, {"int", 40'd0}, {"print", 24'd0}, {"find", 32'd0},
    {"mov", 40'd0}, {"to", 48'd0}, {"at", 48'd0}, 64'("selector"),
    {"byte", 32'd0}, {"in", 48'd0}, {"looper", 16'd0}, 64'("function"),
    {"return", 16'd0}
  };
  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd3, 4'd3, 4'd5, 4'd4, 4'd3, 4'd2, 4'd2, 4'd8, 4'd4, 4'd2, 4'd6, 4'd8, 4'd6
  };

  localparam logic [4:0] KIND_NEWLINE = 5'd0;
  localparam logic [4:0] KIND_STRING  = 5'd1;
  localparam logic [4:0] KIND_IDENT   = 5'd2;
  localparam logic [4:0] KIND_KW0     = 5'd3;
  localparam logic [4:0] KIND_DEC     = 5'd16;
  localparam logic [4:0] KIND_HEX     = 5'd17;
  localparam logic [4:0] KIND_EQEQ    = 5'd18;
  localparam logic [4:0] KIND_ASSIGN  = 5'd19;
  localparam logic [4:0] KIND_LPAREN  = 5'd20;
  localparam logic [4:0] KIND_RPAREN  = 5'd21;
  localparam logic [4:0] KIND_LBRACE  = 5'd22;
  localparam logic [4:0] KIND_RBRACE  = 5'd23;
  localparam logic [4:0] KIND_PLUS    = 5'd24;
  localparam logic [4:0] KIND_ARROW   = 5'd25;
  localparam logic [4:0] KIND_MINUS   = 5'd26;
  localparam logic [4:0] KIND_STAR    = 5'd27;
  localparam logic [4:0] KIND_SLASH   = 5'd28;
  localparam logic [4:0] KIND_END     = 5'd29;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_LOW_X  = 8'h78;
  localparam logic [7:0] CH_UP_X   = 8'h58;

  typedef struct packed {
    logic [4:0]  kind;
    logic [31:0] text_start;
    logic [31:0] text_length;
  } tok_t;

  // All tokens caused by one request; n is 0 to 3.
  typedef struct packed {
    logic [1:0]       n;
    tok_t [2:0]       toks;
  } bundle_t;

  typedef struct packed {
    logic full;
    logic head_valid;
  } q_stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A]};
  endfunction

  function automatic logic is_xdigit(input logic [7:0] c);
    return c inside {[8'h30:8'h39], [8'h61:8'h66], [8'h41:8'h46]};
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c inside {8'h20, [8'h09:8'h0D]};
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic logic [31:0] to32(input logic [POS_BITS-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return w[31:0];
  endfunction

  function automatic tok_t mk_tok(input logic [4:0] kind,
                                  input logic [POS_BITS-1:0] start,
                                  input logic [POS_BITS-1:0] len);
    tok_t t;
    t.kind = kind;
    t.text_start = to32(start);
    t.text_length = to32(len);
    return t;
  endfunction

  // Drops every keyword whose character at offset idx is not c, and every keyword when in_range is low.
  function automatic logic [KW_COUNT-1:0] kw_filter(input logic [KW_COUNT-1:0] mask,
                                                    input logic in_range,
                                                    input logic [2:0] idx,
                                                    input logic [7:0] c);
    logic [KW_COUNT-1:0] m;
    logic [63:0] txt;
    m = mask;
    for (int k = 0; k < KW_COUNT; k++) begin
      txt = KW_TEXT[k] << {idx, 3'b000};
      if (!(in_range && ({1'b0, idx} < KW_LEN[k]) && (txt[63:56] == c))) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

endpackage

// ----- hdl/stt_front.sv -----
// Front end: accepts source requests, runs the scanner and forms token bundles.
module stt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_ready,
  input  logic              cmd,
  input  logic [7:0]        ch,
  input  stt_pkg::q_stat_t  qstat,
  output logic              push,
  output stt_pkg::bundle_t  bundle
);
  import stt_pkg::*;

  localparam logic [3:0] M_IDLE  = 4'd0;
  localparam logic [3:0] M_DSTR  = 4'd1;
  localparam logic [3:0] M_SQ1   = 4'd2;
  localparam logic [3:0] M_SQ2   = 4'd3;
  localparam logic [3:0] M_IDENT = 4'd4;
  localparam logic [3:0] M_ZERO  = 4'd5;
  localparam logic [3:0] M_ZEROX = 4'd6;
  localparam logic [3:0] M_DEC   = 4'd7;
  localparam logic [3:0] M_HEX   = 4'd8;
  localparam logic [3:0] M_EQ    = 4'd9;
  localparam logic [3:0] M_MINUS = 4'd10;

  logic [3:0]          mode, mode_next;
  logic [POS_BITS-1:0] pos, pos_next;
  logic [POS_BITS-1:0] tbeg, tbeg_next;
  logic [KW_COUNT-1:0] kwc, kwc_next;
  logic                fin, fin_next;

  logic [POS_BITS-1:0] span;
  logic                ft_emit;
  logic [4:0]          ft_kind;
  logic [POS_BITS-1:0] ft_len;
  logic                redo;
  logic [1:0]          cnt;
  tok_t [2:0]          toks;
  logic                accept;

  assign src_ready = !qstat.full;
  assign accept = src_valid && src_ready;
  assign bundle.n = cnt;
  assign bundle.toks = toks;
  assign push = accept && !fin && (cnt != 2'd0);

  // Token that a pending multi-byte mode gives when it is cut off.
  always_comb begin
    span = pos - tbeg;
    ft_emit = 1'b1;
    ft_kind = KIND_IDENT;
    ft_len = span;
    case (mode)
      M_IDENT: begin
        for (int k = 0; k < KW_COUNT; k++) begin
          if (kwc[k] && (span == POS_BITS'(KW_LEN[k]))) begin
            ft_kind = 5'(KIND_KW0 + 5'(k));
          end
        end
      end
      M_ZERO, M_DEC: ft_kind = KIND_DEC;
      M_HEX: ft_kind = KIND_HEX;
      M_EQ: begin
        ft_kind = KIND_ASSIGN;
        ft_len = POS_ONE;
      end
      M_MINUS: begin
        ft_kind = KIND_MINUS;
        ft_len = POS_ONE;
      end
      default: ft_emit = 1'b0;
    endcase
  end

  always_comb begin
    mode_next = mode;
    pos_next = pos;
    tbeg_next = tbeg;
    kwc_next = kwc;
    fin_next = fin;
    redo = 1'b0;
    cnt = 2'd0;
    toks = '0;

    if (cmd) begin
      case (mode)
        M_DSTR: begin
          toks[cnt] = mk_tok(KIND_STRING, tbeg, span);
          cnt = cnt + 2'd1;
        end
        M_ZEROX: begin
          toks[cnt] = mk_tok(KIND_DEC, tbeg, POS_ONE);
          cnt = cnt + 2'd1;
          toks[cnt] = mk_tok(KIND_IDENT, sat_inc(tbeg), POS_ONE);
          cnt = cnt + 2'd1;
        end
        default: begin
          if (ft_emit) begin
            toks[cnt] = mk_tok(ft_kind, tbeg, ft_len);
            cnt = cnt + 2'd1;
          end
        end
      endcase
      toks[cnt] = mk_tok(KIND_END, pos, POS_ZERO);
      cnt = cnt + 2'd1;
      mode_next = M_IDLE;
      fin_next = 1'b1;
    end else begin
      case (mode)
        M_IDLE: redo = 1'b1;
        M_DSTR: begin
          if (ch == CH_DQUOTE) begin
            toks[cnt] = mk_tok(KIND_STRING, tbeg, span);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
          end
        end
        M_SQ1: begin
          if (ch == CH_SQUOTE) begin
            mode_next = M_IDLE;
          end else begin
            toks[cnt] = mk_tok(KIND_STRING, pos, POS_ONE);
            cnt = cnt + 2'd1;
            mode_next = M_SQ2;
          end
        end
        M_SQ2: begin
          mode_next = M_IDLE;
          redo = (ch != CH_SQUOTE);
        end
        M_IDENT: begin
          if (is_alpha(ch) || is_digit(ch) || ch == CH_UNDER) begin
            kwc_next = kw_filter(kwc, span < KW_MAX_LEN, span[2:0], ch);
          end else begin
            toks[cnt] = mk_tok(ft_kind, tbeg, ft_len);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
            redo = 1'b1;
          end
        end
        M_ZERO: begin
          if (ch == CH_LOW_X || ch == CH_UP_X) begin
            mode_next = M_ZEROX;
          end else if (is_digit(ch)) begin
            mode_next = M_DEC;
          end else begin
            toks[cnt] = mk_tok(ft_kind, tbeg, ft_len);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
            redo = 1'b1;
          end
        end
        M_ZEROX: begin
          mode_next = M_HEX;
          // A non-hex byte right after the prefix still closes a hex token.
          if (!is_xdigit(ch)) begin
            toks[cnt] = mk_tok(KIND_HEX, tbeg, span);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
            redo = 1'b1;
          end
        end
        M_DEC, M_HEX: begin
          if ((mode == M_DEC) ? !is_digit(ch) : !is_xdigit(ch)) begin
            toks[cnt] = mk_tok(ft_kind, tbeg, ft_len);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
            redo = 1'b1;
          end
        end
        M_EQ, M_MINUS: begin
          if ((mode == M_EQ) ? (ch == CH_EQ) : (ch == CH_GT)) begin
            toks[cnt] = mk_tok((mode == M_EQ) ? KIND_EQEQ : KIND_ARROW, tbeg, POS_TWO);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
          end else begin
            toks[cnt] = mk_tok(ft_kind, tbeg, ft_len);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
            redo = 1'b1;
          end
        end
        default: begin
          mode_next = M_IDLE;
          redo = 1'b1;
        end
      endcase

      // The byte is scanned again from the idle state and may start a new token.
      if (redo) begin
        if (ch == CH_NL) begin
          toks[cnt] = mk_tok(KIND_NEWLINE, pos, POS_ONE);
          cnt = cnt + 2'd1;
        end else if (is_space(ch)) begin
          mode_next = M_IDLE;
        end else if (ch == CH_DQUOTE) begin
          mode_next = M_DSTR;
          tbeg_next = sat_inc(pos);
        end else if (ch == CH_SQUOTE) begin
          mode_next = M_SQ1;
        end else if (is_alpha(ch)) begin
          mode_next = M_IDENT;
          tbeg_next = pos;
          kwc_next = kw_filter(KW_ALL, 1'b1, 3'd0, ch);
        end else if (is_digit(ch)) begin
          mode_next = (ch == CH_ZERO) ? M_ZERO : M_DEC;
          tbeg_next = pos;
        end else begin
          case (ch)
            CH_EQ: begin
              mode_next = M_EQ;
              tbeg_next = pos;
            end
            CH_MINUS: begin
              mode_next = M_MINUS;
              tbeg_next = pos;
            end
            CH_LPAREN: begin
              toks[cnt] = mk_tok(KIND_LPAREN, pos, POS_ONE);
              cnt = cnt + 2'd1;
            end
            CH_RPAREN: begin
              toks[cnt] = mk_tok(KIND_RPAREN, pos, POS_ONE);
              cnt = cnt + 2'd1;
            end
            CH_LBRACE: begin
              toks[cnt] = mk_tok(KIND_LBRACE, pos, POS_ONE);
              cnt = cnt + 2'd1;
            end
            CH_RBRACE: begin
              toks[cnt] = mk_tok(KIND_RBRACE, pos, POS_ONE);
              cnt = cnt + 2'd1;
            end
            CH_PLUS: begin
              toks[cnt] = mk_tok(KIND_PLUS, pos, POS_ONE);
              cnt = cnt + 2'd1;
            end
            CH_STAR: begin
              toks[cnt] = mk_tok(KIND_STAR, pos, POS_ONE);
              cnt = cnt + 2'd1;
            end
            CH_SLASH: begin
              toks[cnt] = mk_tok(KIND_SLASH, pos, POS_ONE);
              cnt = cnt + 2'd1;
            end
            default: mode_next = M_IDLE;
          endcase
        end
      end
      pos_next = sat_inc(pos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= M_IDLE;
      pos <= '0;
      tbeg <= '0;
      kwc <= KW_ALL;
      fin <= 1'b0;
    end else if (accept && !fin) begin
      mode <= mode_next;
      pos <= pos_next;
      tbeg <= tbeg_next;
      kwc <= kwc_next;
      fin <= fin_next;
    end
  end

endmodule

// ----- hdl/stt_queue.sv -----
// Short queue of token bundles between the scanner and the output stage.
module stt_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  stt_pkg::bundle_t  wr_data,
  input  logic              pop,
  output stt_pkg::q_stat_t  qstat,
  output stt_pkg::bundle_t  head
);
  import stt_pkg::*;

  bundle_t              slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign qstat.full = (count == QCNT_BITS'(QDEPTH));
  assign qstat.head_valid = (count != '0);
  assign head = slots[rd_ptr];

  function automatic logic [QPTR_BITS-1:0] ptr_inc(input logic [QPTR_BITS-1:0] p);
    return (p == QPTR_BITS'(QDEPTH - 1)) ? '0 : p + QPTR_BITS'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_BITS'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_BITS'(1);
      end
    end
  end

endmodule

// ----- hdl/stt_back.sv -----
// Back end: unpacks bundles into single tokens behind the output register.
module stt_back (
  input  logic              clk,
  input  logic              rst,
  input  stt_pkg::q_stat_t  qstat,
  input  stt_pkg::bundle_t  head,
  output logic              pop,
  output logic              tok_valid,
  input  logic              tok_ready,
  output logic [4:0]        kind,
  output logic [31:0]       text_start,
  output logic [31:0]       text_length,
  output logic              last_of_run
);
  import stt_pkg::*;

  logic [1:0] idx;
  logic       load;
  logic       at_last;
  tok_t       cur;

  assign load = qstat.head_valid && (!tok_valid || tok_ready);
  assign cur = head.toks[idx];
  assign at_last = (idx == head.n - 2'd1);
  assign pop = load && at_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
      idx <= 2'd0;
    end else if (load) begin
      tok_valid <= 1'b1;
      idx <= at_last ? 2'd0 : idx + 2'd1;
    end else if (tok_ready) begin
      tok_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      kind <= cur.kind;
      text_start <= cur.text_start;
      text_length <= cur.text_length;
      last_of_run <= at_last;
    end
  end

endmodule

// ----- hdl/source_text_tokenizer_core.sv -----
// With the queue empty, the first token of a request passes the queue slot and then the output register.
// Throughput: one request per cycle while the four-entry bundle queue has room.
// The output register drains one token per cycle while tok_ready is high, so a
// request that yields two or three tokens presents them one after another.
// Reset is synchronous; it clears the scanner state and empties the queue.
`include "source_text_tokenizer_core_defines.svh"
module source_text_tokenizer_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        src_valid,
  output logic        src_ready,
  input  logic        cmd,
  input  logic [7:0]  ch,
  output logic        tok_valid,
  input  logic        tok_ready,
  output logic [4:0]  kind,
  output logic [31:0] text_start,
  output logic [31:0] text_length,
  output logic        last_of_run
);
  import stt_pkg::*;

  logic    push;
  logic    pop;
  bundle_t bundle;
  bundle_t head;
  q_stat_t qstat;

  stt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_ready (src_ready),
    .cmd       (cmd),
    .ch        (ch),
    .qstat     (qstat),
    .push      (push),
    .bundle    (bundle)
  );

  stt_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (bundle),
    .pop     (pop),
    .qstat   (qstat),
    .head    (head)
  );

  stt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .qstat       (qstat),
    .head        (head),
    .pop         (pop),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .kind        (kind),
    .text_start  (text_start),
    .text_length (text_length),
    .last_of_run (last_of_run)
  );

  `STT_ASSERT(a_push_room, (push |-> !qstat.full))
  `STT_ASSERT(a_push_nonempty, (push |-> (bundle.n != 2'd0)))
  `STT_ASSERT(a_end_is_last, ((tok_valid && kind == KIND_END) |-> last_of_run))
  `STT_ASSERT_NEXT(a_pop_frees, (pop && !push && qstat.full), !qstat.full)

endmodule

// ----- tb/source_text_tokenizer_core_tb.sv -----
// Testbench of the source text tokenizer core: directed table, random source text, own predictor.
module source_text_tokenizer_core_tb;
  import stt_pkg::*;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_EOF = 1'b1;
  localparam int RANDOM_ITEMS = 165;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam int DIR_ROWS = 26;
  localparam int SINGLE_OPS = 9;
  localparam logic [7:0] OP_BYTES [SINGLE_OPS] = '{
    CH_EQ, CH_MINUS, CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE, CH_PLUS, CH_STAR, CH_SLASH
  };

  typedef enum logic [3:0] {
    SCAN_IDLE, SCAN_DSTR, SCAN_SQ_OPEN, SCAN_SQ_CLOSE, SCAN_WORD, SCAN_ZERO, SCAN_ZERO_X,
    SCAN_DEC, SCAN_HEX, SCAN_EQ, SCAN_MINUS
  } scan_t;

  typedef struct {
    logic [4:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
    logic        last;
  } token_t;

  typedef struct {
    logic        cmd;
    logic [7:0]  ch;
    bit          typed;
    logic [4:0]  kind;
    logic [31:0] start;
    logic [31:0] len;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        src_valid = 1'b0;
  logic        src_ready;
  logic        cmd = CMD_BYTE;
  logic [7:0]  ch = 8'h00;
  logic        tok_valid;
  logic        tok_ready = 1'b0;
  logic [4:0]  kind;
  logic [31:0] text_start;
  logic [31:0] text_length;
  logic        last_of_run;

  // Predictor state.
  scan_t                 scan_state = SCAN_IDLE;
  logic [POS_BITS-1:0]   cur_pos = '0;
  logic [POS_BITS-1:0]   tok_first = '0;
  logic [KW_COUNT-1:0]   kw_mask = KW_ALL;
  bit                    ended = 1'b0;

  token_t     new_toks[$];
  token_t     expected_toks[$];
  logic [7:0] src_bytes[$];
  dir_row_t   dir_rows [DIR_ROWS];
  int         mismatches = 0;
  int         stall_cycles = 0;
  int         tx_idle_pct = 7;
  int         rx_idle_pct = 57;

  source_text_tokenizer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .src_valid   (src_valid),
    .src_ready   (src_ready),
    .cmd         (cmd),
    .ch          (ch),
    .tok_valid   (tok_valid),
    .tok_ready   (tok_ready),
    .kind        (kind),
    .text_start  (text_start),
    .text_length (text_length),
    .last_of_run (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [POS_BITS-1:0] pos_next(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : v + POS_ONE;
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_hexdig(input logic [7:0] c);
    return is_num(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == " " || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic [7:0] kw_char(input int k, input int i);
    return KW_TEXT[k][63 - 8*i -: 8];
  endfunction

  function automatic logic [KW_COUNT-1:0] narrow_keywords(input logic [KW_COUNT-1:0] mask,
                                                          input logic [31:0] idx,
                                                          input logic [7:0] c);
    logic [KW_COUNT-1:0] m;
    m = mask;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (idx >= 32'(KW_LEN[k])) begin
        m[k] = 1'b0;
      end else if (kw_char(k, int'(idx)) != c) begin
        m[k] = 1'b0;
      end
    end
    return m;
  endfunction

  task automatic add_token(input logic [4:0] k, input logic [31:0] s, input logic [31:0] n);
    new_toks.insert(new_toks.size(), token_t'{k, s, n, 1'b0});
  endtask

  task automatic put_byte(input logic [7:0] b);
    src_bytes.insert(src_bytes.size(), b);
  endtask

  // Flushes the multi-byte token that ends just before offset p.
  task automatic close_token(input logic [POS_BITS-1:0] p);
    logic [31:0] n;
    logic [4:0]  k_out;
    n = p - tok_first;
    case (scan_state)
      SCAN_WORD: begin
        k_out = KIND_IDENT;
        for (int k = 0; k < KW_COUNT; k++) begin
          if (kw_mask[k] && n == 32'(KW_LEN[k])) k_out = KIND_KW0 + 5'(k);
        end
        add_token(k_out, tok_first, n);
      end
      SCAN_ZERO, SCAN_DEC: add_token(KIND_DEC, tok_first, n);
      SCAN_HEX: add_token(KIND_HEX, tok_first, n);
      SCAN_EQ: add_token(KIND_ASSIGN, tok_first, 32'd1);
      SCAN_MINUS: add_token(KIND_MINUS, tok_first, 32'd1);
      default: ;
    endcase
    scan_state = SCAN_IDLE;
  endtask

  task automatic open_token(input logic [7:0] c, input logic [POS_BITS-1:0] p);
    if (c == CH_NL) begin
      add_token(KIND_NEWLINE, p, 32'd1);
    end else if (is_blank(c)) begin
    end else if (c == CH_DQUOTE) begin
      scan_state = SCAN_DSTR;
      tok_first = pos_next(p);
    end else if (c == CH_SQUOTE) begin
      scan_state = SCAN_SQ_OPEN;
    end else if (is_letter(c)) begin
      scan_state = SCAN_WORD;
      tok_first = p;
      kw_mask = narrow_keywords(KW_ALL, 32'd0, c);
    end else if (is_num(c)) begin
      scan_state = (c == CH_ZERO) ? SCAN_ZERO : SCAN_DEC;
      tok_first = p;
    end else begin
      case (c)
        CH_EQ: begin
          scan_state = SCAN_EQ;
          tok_first = p;
        end
        CH_MINUS: begin
          scan_state = SCAN_MINUS;
          tok_first = p;
        end
        CH_LPAREN: add_token(KIND_LPAREN, p, 32'd1);
        CH_RPAREN: add_token(KIND_RPAREN, p, 32'd1);
        CH_LBRACE: add_token(KIND_LBRACE, p, 32'd1);
        CH_RBRACE: add_token(KIND_RBRACE, p, 32'd1);
        CH_PLUS: add_token(KIND_PLUS, p, 32'd1);
        CH_STAR: add_token(KIND_STAR, p, 32'd1);
        CH_SLASH: add_token(KIND_SLASH, p, 32'd1);
        default: ;
      endcase
    end
  endtask

  // Works out the tokens that one accepted request gives, into new_toks.
  task automatic scan_request(input logic c_end, input logic [7:0] c);
    logic [POS_BITS-1:0] p;
    bit rescan;
    new_toks.delete();
    p = cur_pos;
    rescan = 1'b0;
    if (ended) return;
    if (c_end == CMD_EOF) begin
      case (scan_state)
        SCAN_DSTR: add_token(KIND_STRING, tok_first, p - tok_first);
        SCAN_ZERO_X: begin
          // A bare 0x at the end splits into a zero and an identifier x.
          add_token(KIND_DEC, tok_first, 32'd1);
          add_token(KIND_IDENT, pos_next(tok_first), 32'd1);
        end
        SCAN_IDLE, SCAN_SQ_OPEN, SCAN_SQ_CLOSE: ;
        default: close_token(p);
      endcase
      add_token(KIND_END, p, 32'd0);
      scan_state = SCAN_IDLE;
      ended = 1'b1;
    end else begin
      case (scan_state)
        SCAN_IDLE: rescan = 1'b1;
        SCAN_DSTR: begin
          if (c == CH_DQUOTE) begin
            add_token(KIND_STRING, tok_first, p - tok_first);
            scan_state = SCAN_IDLE;
          end
        end
        SCAN_SQ_OPEN: begin
          if (c == CH_SQUOTE) begin
            scan_state = SCAN_IDLE;
          end else begin
            add_token(KIND_STRING, p, 32'd1);
            scan_state = SCAN_SQ_CLOSE;
          end
        end
        SCAN_SQ_CLOSE: begin
          scan_state = SCAN_IDLE;
          rescan = (c != CH_SQUOTE);
        end
        SCAN_WORD: begin
          if (is_letter(c) || is_num(c) || c == CH_UNDER) begin
            kw_mask = narrow_keywords(kw_mask, p - tok_first, c);
          end else begin
            close_token(p);
            rescan = 1'b1;
          end
        end
        SCAN_ZERO: begin
          if (c == CH_LOW_X || c == CH_UP_X) begin
            scan_state = SCAN_ZERO_X;
          end else if (is_num(c)) begin
            scan_state = SCAN_DEC;
          end else begin
            close_token(p);
            rescan = 1'b1;
          end
        end
        SCAN_ZERO_X: begin
          scan_state = SCAN_HEX;
          if (!is_hexdig(c)) begin
            close_token(p);
            rescan = 1'b1;
          end
        end
        SCAN_DEC: begin
          if (!is_num(c)) begin
            close_token(p);
            rescan = 1'b1;
          end
        end
        SCAN_HEX: begin
          if (!is_hexdig(c)) begin
            close_token(p);
            rescan = 1'b1;
          end
        end
        SCAN_EQ: begin
          if (c == CH_EQ) begin
            add_token(KIND_EQEQ, tok_first, 32'd2);
            scan_state = SCAN_IDLE;
          end else begin
            close_token(p);
            rescan = 1'b1;
          end
        end
        SCAN_MINUS: begin
          if (c == CH_GT) begin
            add_token(KIND_ARROW, tok_first, 32'd2);
            scan_state = SCAN_IDLE;
          end else begin
            close_token(p);
            rescan = 1'b1;
          end
        end
        default: begin
          scan_state = SCAN_IDLE;
          rescan = 1'b1;
        end
      endcase
      if (rescan) open_token(c, p);
      cur_pos = pos_next(p);
    end
    if (new_toks.size() > 0) new_toks[new_toks.size() - 1].last = 1'b1;
  endtask

  // Presents one request, waits for it to be taken and records what it should give.
  task automatic send_request(input logic c_end, input logic [7:0] c, input bit typed,
                              input token_t typed_tok);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    cmd <= c_end;
    ch <= c;
    do @(posedge clk); while (!src_ready);
    scan_request(c_end, c);
    if (typed) begin
      new_toks.delete();
      new_toks.insert(new_toks.size(), typed_tok);
    end
    foreach (new_toks[i]) expected_toks.insert(expected_toks.size(), new_toks[i]);
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
  endfunction

  function automatic logic [7:0] rand_word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 52) return rand_letter();
    if (r < 62) return 8'("0" + r - 52);
    return CH_UNDER;
  endfunction

  function automatic logic [7:0] rand_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("a" + r - 10);
    return 8'("A" + r - 16);
  endfunction

  // Appends one random piece of source text, mostly well formed, to src_bytes.
  task automatic add_fragment();
    int sel;
    int n;
    int k;
    logic [7:0] b;
    sel = $urandom_range(0, 19);
    if (sel < 4) begin
      k = $urandom_range(0, KW_COUNT - 1);
      n = int'(KW_LEN[k]);
      if ($urandom_range(3) == 0) n = $urandom_range(1, int'(KW_LEN[k]));
      for (int i = 0; i < n; i++) put_byte(kw_char(k, i));
      if ($urandom_range(3) == 0) put_byte(rand_word_char());
    end else if (sel < 6) begin
      put_byte(rand_letter());
      repeat ($urandom_range(0, 5)) put_byte(rand_word_char());
    end else if (sel < 8) begin
      put_byte(8'("0" + $urandom_range(0, 9)));
      repeat ($urandom_range(0, 3)) put_byte(8'("0" + $urandom_range(0, 9)));
    end else if (sel < 10) begin
      put_byte(CH_ZERO);
      put_byte($urandom_range(1) ? CH_LOW_X : CH_UP_X);
      repeat ($urandom_range(0, 4)) put_byte(rand_hex_char());
    end else if (sel == 10) begin
      put_byte(CH_DQUOTE);
      repeat ($urandom_range(0, 5)) begin
        b = 8'($urandom_range(0, 255));
        if (b == CH_DQUOTE) b = CH_SQUOTE;
        put_byte(b);
      end
      put_byte(CH_DQUOTE);
    end else if (sel == 11) begin
      put_byte(CH_SQUOTE);
      put_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(1)) put_byte(CH_SQUOTE);
    end else if (sel < 15) begin
      n = $urandom_range(0, SINGLE_OPS + 1);
      if (n < SINGLE_OPS) begin
        put_byte(OP_BYTES[n]);
      end else if (n == SINGLE_OPS) begin
        put_byte(CH_EQ);
        put_byte(CH_EQ);
      end else begin
        put_byte(CH_MINUS);
        put_byte(CH_GT);
      end
    end else if (sel < 17) begin
      put_byte($urandom_range(1) ? CH_NL : 8'($urandom_range(8'h09, 8'h0D)));
    end else if (sel < 19) begin
      put_byte(8'($urandom_range(0, 255)));
    end else begin
      put_byte(8'($urandom_range(128, 255)));
    end
    if ($urandom_range(1)) put_byte(" ");
  endtask

  // Compares every token taken by the receiver with the oldest expectation.
  always @(posedge clk) begin : check_tokens
    token_t want;
    if (!rst && tok_valid && tok_ready) begin
      if (expected_toks.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("unexpected token: kind %0d start %0d length %0d last %0b",
                   kind, text_start, text_length, last_of_run);
        end
      end else begin
        want = expected_toks.pop_front();
        if (kind !== want.kind || text_start !== want.start || text_length !== want.len ||
            last_of_run !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display({"token mismatch: expected kind %0d start %0d length %0d last %0b,",
                      " got %0d %0d %0d %0b"},
                     want.kind, want.start, want.len, want.last,
                     kind, text_start, text_length, last_of_run);
          end
        end
      end
    end
    tok_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (src_valid && src_ready) || (tok_valid && tok_ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("source_text_tokenizer_core: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    token_t no_tok;
    int third;
    no_tok = '{default: '0};
    dir_rows = '{
      '{CMD_BYTE, CH_NL,     1'b1, KIND_NEWLINE, 32'd0,  32'd1},
      '{CMD_BYTE, CH_LPAREN, 1'b1, KIND_LPAREN,  32'd1,  32'd1},
      '{CMD_BYTE, CH_RPAREN, 1'b1, KIND_RPAREN,  32'd2,  32'd1},
      '{CMD_BYTE, CH_LBRACE, 1'b1, KIND_LBRACE,  32'd3,  32'd1},
      '{CMD_BYTE, CH_RBRACE, 1'b1, KIND_RBRACE,  32'd4,  32'd1},
      '{CMD_BYTE, CH_PLUS,   1'b1, KIND_PLUS,    32'd5,  32'd1},
      '{CMD_BYTE, CH_STAR,   1'b1, KIND_STAR,    32'd6,  32'd1},
      '{CMD_BYTE, CH_SLASH,  1'b1, KIND_SLASH,   32'd7,  32'd1},
      '{CMD_BYTE, 8'hFF,     1'b0, '0,           '0,     '0},
      '{CMD_BYTE, 8'h00,     1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_EQ,     1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_EQ,     1'b1, KIND_EQEQ,    32'd10, 32'd2},
      '{CMD_BYTE, CH_MINUS,  1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_GT,     1'b1, KIND_ARROW,   32'd12, 32'd2},
      '{CMD_BYTE, CH_MINUS,  1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_EQ,     1'b0, '0,           '0,     '0},
      '{CMD_BYTE, "t",       1'b0, '0,           '0,     '0},
      '{CMD_BYTE, "o",       1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_SQUOTE, 1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_SQUOTE, 1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_ZERO,   1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_LOW_X,  1'b0, '0,           '0,     '0},
      '{CMD_BYTE, "g",       1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_DQUOTE, 1'b0, '0,           '0,     '0},
      '{CMD_BYTE, "a",       1'b0, '0,           '0,     '0},
      '{CMD_BYTE, CH_DQUOTE, 1'b0, '0,           '0,     '0}
    };

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      send_request(dir_rows[i].cmd, dir_rows[i].ch, dir_rows[i].typed,
                   token_t'{dir_rows[i].kind, dir_rows[i].start, dir_rows[i].len, 1'b1});
    end

    while (src_bytes.size() < RANDOM_ITEMS) add_fragment();
    third = src_bytes.size() / 3;
    foreach (src_bytes[i]) begin
      if (i == third) begin
        // Hold the source back until the token queue has fully drained.
        src_valid <= 1'b0;
        do @(posedge clk); while (expected_toks.size() != 0);
        tx_idle_pct = 57;
        rx_idle_pct = 7;
      end
      if (i == 2 * third) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_request(CMD_BYTE, src_bytes[i], 1'b0, no_tok);
    end

    // Usually leave a random token pending so the end of input has something to flush.
    src_bytes.delete();
    case ($urandom_range(0, 6))
      1: begin
        put_byte(CH_ZERO);
        put_byte(CH_LOW_X);
      end
      2: begin
        put_byte(CH_DQUOTE);
        put_byte("a");
      end
      3: put_byte(CH_SQUOTE);
      4: for (int i = 0; i < int'(KW_LEN[10]); i++) put_byte(kw_char(10, i));
      5: put_byte(CH_EQ);
      6: put_byte(CH_MINUS);
      default: ;
    endcase
    foreach (src_bytes[i]) send_request(CMD_BYTE, src_bytes[i], 1'b0, no_tok);
    send_request(CMD_EOF, 8'($urandom_range(0, 255)), 1'b0, no_tok);
    // Requests after the end of input must be taken and give nothing.
    repeat (4) send_request(1'($urandom_range(1)), 8'($urandom_range(0, 255)), 1'b0, no_tok);
    src_valid <= 1'b0;

    do @(posedge clk); while (expected_toks.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_toks.size() == 0) begin
      $display("source_text_tokenizer_core: match");
    end else begin
      $display("source_text_tokenizer_core: mismatch");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_front.sv
hdl/stt_queue.sv
hdl/stt_back.sv
hdl/source_text_tokenizer_core.sv
tb/source_text_tokenizer_core_tb.sv
